// ----- rtl/core/ddds_pkg.sv -----
`timescale 1ns / 1ps
package ddds_pkg;

	localparam int DateW = 27;
	localparam int YearW = 14;
	localparam int RemW  = 14;
	localparam int MonW  = 7;
	localparam int DayW  = 7;
	localparam int CentW = 8;
	localparam int DimW  = 5;

	localparam logic KindNext = 1'b0;
	localparam logic KindPrev = 1'b1;

	localparam int YearScale  = 10000;
	localparam int MonthScale = 100;
	localparam int LastYear   = 9999;
	localparam int FirstYear  = 1;
	localparam int LastMonth  = 12;

	// floor(n / 625) for n < 2**23: (n * Div625Recip) >> Div625Shift, low by at most one
	localparam logic [22:0] Div625Recip = 23'd6871947;
	localparam int          Div625Shift = 32;

	// floor(x / 25) for x < 3400, exact
	localparam logic [10:0] Div25Recip = 11'd1311;
	localparam int          Div25Shift = 15;

	// packed-date offsets for carries and borrows
	localparam logic [DateW-1:0] DayStep   = 27'd1;
	localparam logic [DateW-1:0] MonthStep = 27'd101;
	localparam logic [DateW-1:0] YearStep  = 27'd8870;

	localparam logic [DateW-1:0] MinDate = 27'd10101;
	localparam logic [DateW-1:0] MaxDate = 27'd99991231;

	function automatic logic [CentW-1:0] div25(input logic [11:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(Div25Recip);
		return p[22:Div25Shift];
	endfunction

	function automatic logic [DimW-1:0] days_in(input logic [MonW-1:0] m, input logic leap);
		logic [DimW-1:0] n;
		case (m) inside
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    n = 5'd30;
			7'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

// ----- rtl/core/decimal_date_day_step_core.sv -----
`timescale 1ns / 1ps
// Steps a packed decimal date YYYYMMDD one day forward (kind 0) or back (kind 1) on the
// proleptic Gregorian calendar. One beat is accepted per cycle while the result side does
// not stall; each beat passes through the input register and the five stages behind it:
// reciprocal multiply for the year split, its correction, the month and century digits,
// the day and leap test, and the step itself into the result register. Stalls on the
// result side back up through the stages. A year of 0 or above 9999, a month outside 1
// to 12, a day outside the month, and a step past 99991231 or before 00010101 all give
// bad_date = 1 with result_date = 0.
module decimal_date_day_step_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        kind,
	input  logic [ddds_pkg::DateW-1:0]  date_value,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [ddds_pkg::DateW-1:0]  result_date,
	output logic                        bad_date
);
	import ddds_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic             kind_s1, kind_s2, kind_s3, kind_s4, kind_s5;
	logic [DateW-1:0] date_s1, date_s2, date_s3, date_s4, date_s5;
	logic [YearW-1:0] q_s2;
	logic [YearW-1:0] y_s3, y_s4, y_s5;
	logic [RemW-1:0]  rem_s3, rem_s4;
	logic [MonW-1:0]  m_s4, m_s5;
	logic [CentW-1:0] c_s4;
	logic [DayW-1:0]  d_s5;
	logic             leap_s5;
	logic [DateW-1:0] res_date_s6;
	logic             bad_s6;

	// stage A: year estimate
	logic [45:0]      prod_a;
	logic [YearW-1:0] q_a;

	// stage B: year correction and remainder
	logic [DateW-1:0] y_scaled_b;
	logic [DateW-1:0] rem_wide_b;
	logic [14:0]      rem0_b;
	logic             wrap_b;
	logic [YearW-1:0] y_b;
	logic [RemW-1:0]  rem_b;

	// stage C: month and century
	logic [CentW-1:0] m_wide_c;
	logic [CentW-1:0] c_c;

	// stage D: day and leap
	logic [RemW-1:0]  mon_scaled_d;
	logic [RemW-1:0]  d_wide_d;
	logic [DayW-1:0]  d_d;
	logic [YearW-1:0] cent_scaled_d;
	logic             div100_d;
	logic             leap_d;

	// stage E: check and step
	logic [DimW-1:0]  dim_e;
	logic [DimW-1:0]  dim_prev_e;
	logic             in_ok_e;
	logic             bad_e;
	logic [DateW-1:0] res_e;

	assign en_s6 = !v_s6 || !rsp_stall;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign req_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= req_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_comb begin
		prod_a = 46'(date_s1[DateW-1:4]) * 46'(Div625Recip);
		q_a    = prod_a[45:Div625Shift];
	end

	always_comb begin
		y_scaled_b = 27'(q_s2) * 27'(YearScale);
		rem_wide_b = date_s2 - y_scaled_b;
		rem0_b     = rem_wide_b[14:0];
		wrap_b     = rem0_b >= 15'(YearScale);
		y_b        = wrap_b ? q_s2 + 14'd1 : q_s2;
		rem_b      = wrap_b ? 14'(rem0_b - 15'(YearScale)) : rem0_b[RemW-1:0];
	end

	always_comb begin
		m_wide_c = div25(rem_s3[RemW-1:2]);
		c_c      = div25(y_s3[YearW-1:2]);
	end

	always_comb begin
		mon_scaled_d  = 14'(m_s4) * 14'(MonthScale);
		d_wide_d      = rem_s4 - mon_scaled_d;
		d_d           = d_wide_d[DayW-1:0];
		cent_scaled_d = 14'(c_s4) * 14'(MonthScale);
		div100_d      = y_s4 == cent_scaled_d;
		leap_d        = (y_s4[1:0] == 2'b00 && !div100_d) || (div100_d && c_s4[1:0] == 2'b00);
	end

	always_comb begin
		dim_e      = days_in(m_s5, leap_s5);
		dim_prev_e = days_in(7'(m_s5 - 7'd1), leap_s5);
		in_ok_e    = y_s5 != '0 && y_s5 <= 14'(LastYear) && dim_e != '0 &&
			d_s5 != '0 && d_s5 <= 7'(dim_e);
		bad_e      = !in_ok_e;
		res_e      = '0;
		if (in_ok_e) begin
			if (kind_s5 == KindNext) begin
				if (d_s5 < 7'(dim_e)) begin
					res_e = date_s5 + DayStep;
				end else if (m_s5 < 7'(LastMonth)) begin
					res_e = date_s5 - 27'(d_s5) + MonthStep;
				end else if (y_s5 == 14'(LastYear)) begin
					bad_e = 1'b1;
				end else begin
					res_e = date_s5 + YearStep;
				end
			end else begin
				if (d_s5 > 7'd1) begin
					res_e = date_s5 - DayStep;
				end else if (m_s5 > 7'd1) begin
					res_e = date_s5 - MonthStep + 27'(dim_prev_e);
				end else if (y_s5 == 14'(FirstYear)) begin
					bad_e = 1'b1;
				end else begin
					res_e = date_s5 - YearStep;
				end
			end
		end
		if (bad_e) begin
			res_e = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1 <= kind;
			date_s1 <= date_value;
		end
		if (en_s2) begin
			kind_s2 <= kind_s1;
			date_s2 <= date_s1;
			q_s2    <= q_a;
		end
		if (en_s3) begin
			kind_s3 <= kind_s2;
			date_s3 <= date_s2;
			y_s3    <= y_b;
			rem_s3  <= rem_b;
		end
		if (en_s4) begin
			kind_s4 <= kind_s3;
			date_s4 <= date_s3;
			y_s4    <= y_s3;
			rem_s4  <= rem_s3;
			m_s4    <= m_wide_c[MonW-1:0];
			c_s4    <= c_c;
		end
		if (en_s5) begin
			kind_s5 <= kind_s4;
			date_s5 <= date_s4;
			y_s5    <= y_s4;
			m_s5    <= m_s4;
			d_s5    <= d_d;
			leap_s5 <= leap_d;
		end
		if (en_s6) begin
			res_date_s6 <= res_e;
			bad_s6      <= bad_e;
		end
	end

	assign rsp_valid   = v_s6;
	assign result_date = res_date_s6;
	assign bad_date    = bad_s6;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("input stalled while a stage is empty");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && bad_date) |-> (result_date == '0))
		else $error("flagged result carries a date");

	a_good_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !bad_date) |-> (result_date >= MinDate && result_date <= MaxDate))
		else $error("unflagged result outside the calendar");

endmodule

// ----- tb/decimal_date_day_step_core_test.sv -----
`timescale 1ns / 1ps
module decimal_date_day_step_core_test;

	import ddds_pkg::*;

	typedef struct {
		logic             kind;
		logic [DateW-1:0] date;
		bit               drain;
	} date_beat_t;

	typedef struct {
		logic [DateW-1:0] date;
		logic             bad;
	} adjacent_day_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic             kind = 1'b0;
	logic [DateW-1:0] date_value = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	logic [DateW-1:0] result_date;
	logic             bad_date;

	date_beat_t    pending_beats[$];
	adjacent_day_t expected_days[$];
	date_beat_t    next_beat;
	adjacent_day_t want;

	int error_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int flagged_count = 0;
	int prev_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_phase_left = 0;

	decimal_date_day_step_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.date_value  (date_value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.result_date (result_date),
		.bad_date    (bad_date)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned month_length(int unsigned y, int unsigned m);
		bit leap;
		leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
		case (m)
			2:           return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default:     return 0;
		endcase
	endfunction

	function automatic adjacent_day_t step_calendar_day(logic k, logic [DateW-1:0] packed_date);
		int unsigned y, m, d, len;
		adjacent_day_t r;
		y = packed_date / YearScale;
		m = (packed_date % YearScale) / MonthScale;
		d = packed_date % MonthScale;
		r.date = '0;
		r.bad = 1'b1;
		len = month_length(y, m);
		if (y < FirstYear || y > LastYear || len == 0 || d < 1 || d > len)
			return r;
		if (k == KindNext) begin
			if (d < len) begin
				d++;
			end else begin
				d = 1;
				if (m < LastMonth) begin
					m++;
				end else begin
					m = 1;
					y++;
				end
			end
		end else begin
			if (d > 1) begin
				d--;
			end else if (m > 1) begin
				m--;
				d = month_length(y, m);
			end else begin
				y--;
				m = LastMonth;
				d = 31;
			end
		end
		if (y < FirstYear || y > LastYear)
			return r;
		r.date = DateW'(y * YearScale + m * MonthScale + d);
		r.bad = 1'b0;
		return r;
	endfunction

	function automatic logic [DateW-1:0] pack_date(int unsigned y, int unsigned m,
		int unsigned d);
		return DateW'(y * YearScale + m * MonthScale + d);
	endfunction

	function automatic logic [DateW-1:0] random_calendar_date();
		int unsigned y, m, len, sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0:       y = FirstYear;
			1:       y = LastYear;
			2:       y = 100 * $urandom_range(1, 99);
			3:       y = 4 * $urandom_range(1, 2499);
			default: y = $urandom_range(FirstYear, LastYear);
		endcase
		m = $urandom_range(1, LastMonth);
		len = month_length(y, m);
		case ($urandom_range(0, 3))
			0:       return pack_date(y, m, 1);
			1:       return pack_date(y, m, len);
			default: return pack_date(y, m, $urandom_range(1, len));
		endcase
	endfunction

	function automatic logic [DateW-1:0] random_broken_date();
		int unsigned y, m;
		y = $urandom_range(FirstYear, LastYear);
		m = $urandom_range(1, LastMonth);
		case ($urandom_range(0, 5))
			0:       return pack_date(y, m, $urandom_range(month_length(y, m) + 1, 99));
			1:       return pack_date(y, m, 0);
			2:       return pack_date(y, $urandom_range(13, 99), $urandom_range(0, 99));
			3:       return pack_date(y, 0, $urandom_range(0, 99));
			4:       return pack_date(0, m, $urandom_range(0, 99));
			default: return DateW'($urandom);
		endcase
	endfunction

	task automatic add_beat(logic k, logic [DateW-1:0] d, bit drain);
		date_beat_t b;
		b.kind = k;
		b.date = d;
		b.drain = drain;
		pending_beats.push_back(b);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			kind <= KindNext;
			date_value <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_days.push_back(step_calendar_day(kind, date_value));
				sent_count++;
				if (kind == KindPrev)
					prev_count++;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_beats.size() == 0) begin
					req_valid <= 1'b0;
				end else if (pending_beats[0].drain && (req_valid || expected_days.size() != 0)) begin
					req_valid <= 1'b0;
				end else begin
					next_beat = pending_beats.pop_front();
					req_valid <= 1'b1;
					kind <= next_beat.kind;
					date_value <= next_beat.date;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
							: $urandom_range(0, 15);
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode = 0;
			stall_phase_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_days.size() == 0) begin
					$error("unexpected beat: result_date %0d bad_date %0b", result_date, bad_date);
					error_count++;
				end else begin
					want = expected_days.pop_front();
					checked_count++;
					if (want.bad)
						flagged_count++;
					if (result_date !== want.date) begin
						$error("result_date: expected %0d, got %0d", want.date, result_date);
						error_count++;
					end
					if (bad_date !== want.bad) begin
						$error("bad_date: expected %0b, got %0b", want.bad, bad_date);
						error_count++;
					end
				end
			end
			if (stall_phase_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_phase_left = $urandom_range(20, 150);
			end else begin
				stall_phase_left--;
			end
			case (stall_mode)
				0:       rsp_stall <= 1'b0;
				1:       rsp_stall <= ($urandom_range(0, 3) == 0);
				default: rsp_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	initial begin
		#1_000_000;
		$display("decimal_date_day_step_core_test: FAIL");
		$finish;
	end

	initial begin
		add_beat(KindNext, MaxDate, 1'b0);
		add_beat(KindPrev, MinDate, 1'b0);
		add_beat(KindPrev, MaxDate, 1'b0);
		add_beat(KindNext, MinDate, 1'b0);
		add_beat(KindNext, 27'd00000101, 1'b0);
		add_beat(KindPrev, 27'd100000101, 1'b0);
		add_beat(KindNext, 27'd20230015, 1'b0);
		add_beat(KindPrev, 27'd20231315, 1'b0);
		add_beat(KindNext, 27'd20239915, 1'b0);
		add_beat(KindPrev, 27'd20230700, 1'b0);
		add_beat(KindNext, 27'd20230132, 1'b0);
		add_beat(KindPrev, 27'd20230431, 1'b0);
		add_beat(KindNext, 27'd20000229, 1'b0);
		add_beat(KindPrev, 27'd19000229, 1'b0);
		add_beat(KindNext, 27'd19000228, 1'b0);
		add_beat(KindNext, 27'd20240229, 1'b0);
		add_beat(KindPrev, 27'd20240301, 1'b0);
		add_beat(KindPrev, 27'd20230301, 1'b0);
		add_beat(KindNext, 27'd20201231, 1'b0);
		add_beat(KindPrev, 27'd20210101, 1'b0);
		add_beat(KindNext, 27'd20210131, 1'b0);
		add_beat(KindPrev, 27'd20210430, 1'b0);
		add_beat(KindNext, '1, 1'b0);
		add_beat(KindPrev, '0, 1'b0);
		for (int i = 0; i < 1326; i++) begin
			add_beat(logic'($urandom_range(0, 1)),
				($urandom_range(0, 4) == 0) ? random_broken_date() : random_calendar_date(),
				i == 0 || i == 700);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || req_valid || expected_days.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d dates (%0d previous-day, %0d flagged), %0d results checked",
			sent_count, prev_count, flagged_count, checked_count);
		$display("month/year carries, leap rules, range edges and malformed fields exercised");
		if (error_count == 0) begin
			$display("decimal_date_day_step_core_test: PASS");
		end else begin
			$display("decimal_date_day_step_core_test: FAIL");
		end
		$finish;
	end

endmodule
